@@ rtl/io_port_access_pattern_counter_defines.svh @@
// assertion macros for the io port access pattern counter
`ifndef IO_PORT_ACCESS_PATTERN_COUNTER_DEFINES_SVH
`define IO_PORT_ACCESS_PATTERN_COUNTER_DEFINES_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define IOPAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("iopac assertion failed");
// property checked on every clock edge, reset included
`define IOPAC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("iopac assertion failed");
`else
`define IOPAC_ASSERT(lbl, prop)
`define IOPAC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/iopac_pkg.sv @@
// shared types and constants of the io port access pattern counter
package iopac_pkg;

  localparam int unsigned NumPorts     = 5;
  localparam int unsigned PortW        = 16;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned HitW         = 20;
  localparam int unsigned CountBitsDef = 20;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned SeenW        = 3;

  // instruction bytes: operand size prefix, mov dx imm16, in/out via dx
  localparam logic [ByteW-1:0] OpsizePrefix = 8'h66;
  localparam logic [ByteW-1:0] MovDxImm     = 8'hBA;
  // ec, ed, ee and ef share their top six bits
  localparam logic [5:0]       PortIoOpTop  = 6'b111011;

  // byte counter thresholds
  localparam logic [SeenW-1:0] SeenWindow = 3'd4;
  localparam logic [SeenW-1:0] SeenOk     = 3'd5;
  localparam logic [SeenW-1:0] SeenFull   = 3'd6;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegSoundReason = 3'd0,
    RegModemCtrl   = 3'd1,
    RegBootFlag    = 3'd2,
    RegBootType    = 3'd3,
    RegBootUnit    = 3'd4
  } cfg_reg_e;

  // match outcome for one byte
  typedef struct packed {
    logic                any_hit;
    logic [NumPorts-1:0] port_hit;
  } hit_t;

  // one result beat: per-port counts then the total
  typedef struct packed {
    logic                         ok;
    logic [NumPorts:0][HitW-1:0]  hits;
  } result_t;

endpackage

@@ rtl/iopac_match.sv @@
// pattern window check and priority port lookup
module iopac_match (
  input  logic [31:0]                          prior_i,
  input  logic [iopac_pkg::ByteW-1:0]          cur_i,
  input  logic                                 window_full_i,
  input  logic [iopac_pkg::NumPorts-1:0][iopac_pkg::PortW-1:0] ports_i,
  output iopac_pkg::hit_t                      hit_o
);
  import iopac_pkg::*;

  logic             pattern;
  logic [PortW-1:0] port;
  logic [NumPorts-1:0] eq;

  // 66 ba lo hi op with the oldest byte on top
  assign pattern = window_full_i
                && (prior_i[31:24] == OpsizePrefix)
                && (prior_i[23:16] == MovDxImm)
                && (cur_i[7:2] == PortIoOpTop);
  assign port = {prior_i[7:0], prior_i[15:8]};

  // compare against every configured port
  always_comb begin
    for (int k = 0; k < NumPorts; k++) begin
      eq[k] = (port == ports_i[k]);
    end
  end

  // first equal register wins
  always_comb begin
    hit_o.port_hit = '0;
    for (int k = NumPorts - 1; k >= 0; k--) begin
      if (eq[k]) begin
        hit_o.port_hit    = '0;
        hit_o.port_hit[k] = pattern;
      end
    end
    hit_o.any_hit = pattern && (eq != '0);
  end

endmodule

@@ rtl/io_port_access_pattern_counter.sv @@
// top level of the io port access pattern counter
// Scans a code image one byte per beat for the sequence 66 BA lo hi op
// (op EC..EF, overlapping matches allowed) and counts, with saturating
// COUNT_BITS-bit counters, how often the port lo|hi<<8 equals each of five
// configured ports (first equal register wins) and in total. The beat marked
// final_byte_i yields one result beat with the low 20 bits of each count,
// or scan_ok_o low and zero counts when the image held fewer than six bytes;
// the scan state then clears, the port registers stay. A byte is taken every
// cycle unless stalled: it passes an input register, then window compare and
// counter update; the result leaves from a two-entry output buffer, so the
// input stalls only while the second entry holds a result. Configuration is
// always ready.
`include "io_port_access_pattern_counter_defines.svh"

module io_port_access_pattern_counter #(
  parameter int unsigned COUNT_BITS = iopac_pkg::CountBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [iopac_pkg::ByteW-1:0]       image_byte_i,
  input  logic                              final_byte_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              scan_ok_o,
  output logic [iopac_pkg::HitW-1:0]        sound_hits_o,
  output logic [iopac_pkg::HitW-1:0]        modem_hits_o,
  output logic [iopac_pkg::HitW-1:0]        boot_flag_hits_o,
  output logic [iopac_pkg::HitW-1:0]        boot_type_hits_o,
  output logic [iopac_pkg::HitW-1:0]        boot_unit_hits_o,
  output logic [iopac_pkg::HitW-1:0]        all_hits_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [iopac_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [iopac_pkg::PortW-1:0]       cfg_data_i
);
  import iopac_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // port registers
  logic [NumPorts-1:0][PortW-1:0] port_q;

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             final_q;

  // scan state
  logic [31:0]                         prior_q;
  logic [SeenW-1:0]                    seen_q;
  logic [NumPorts-1:0][COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]               total_q, total_d;

  // output buffer
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res_d;

  hit_t hit;
  logic fire;
  logic out_pop;

  assign cfg_ready_o = 1'b1;

  // configuration writes, indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSoundReason: port_q[RegSoundReason] <= cfg_data_i;
        RegModemCtrl:   port_q[RegModemCtrl]   <= cfg_data_i;
        RegBootFlag:    port_q[RegBootFlag]    <= cfg_data_i;
        RegBootType:    port_q[RegBootType]    <= cfg_data_i;
        RegBootUnit:    port_q[RegBootUnit]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a byte moves on unless the skid entry is taken
  assign fire       = in_valid_q && !skid_valid_q;
  assign in_stall_o = in_valid_q && !fire;
  assign out_pop    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= image_byte_i;
      final_q <= final_byte_i;
    end
  end

  iopac_match u_match (
    .prior_i       (prior_q),
    .cur_i         (byte_q),
    .window_full_i (seen_q >= SeenWindow),
    .ports_i       (port_q),
    .hit_o         (hit)
  );

  // saturating counter updates
  always_comb begin
    for (int k = 0; k < NumPorts; k++) begin
      cnt_d[k] = cnt_q[k];
      if (hit.port_hit[k] && (cnt_q[k] != CountMax)) begin
        cnt_d[k] = cnt_q[k] + COUNT_BITS'(1);
      end
    end
    total_d = total_q;
    if (hit.any_hit && (total_q != CountMax)) begin
      total_d = total_q + COUNT_BITS'(1);
    end
  end

  // result of the final byte, zeroed for a short image
  always_comb begin
    res_d.ok = (seen_q >= SeenOk);
    for (int k = 0; k < NumPorts; k++) begin
      res_d.hits[k] = res_d.ok ? HitW'(cnt_d[k]) : '0;
    end
    res_d.hits[NumPorts] = res_d.ok ? HitW'(total_d) : '0;
  end

  // scan state, cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
      seen_q  <= '0;
      cnt_q   <= '0;
      total_q <= '0;
    end else if (fire) begin
      if (final_q) begin
        prior_q <= '0;
        seen_q  <= '0;
        cnt_q   <= '0;
        total_q <= '0;
      end else begin
        prior_q <= {prior_q[23:0], byte_q};
        if (seen_q != SeenFull) begin
          seen_q <= seen_q + SeenW'(1);
        end
        cnt_q   <= cnt_d;
        total_q <= total_d;
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q) begin
        if (out_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (fire && final_q) begin
        if (out_valid_q && !out_pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (fire && final_q) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scan_ok_o        = out_q.ok;
  assign sound_hits_o     = out_q.hits[RegSoundReason];
  assign modem_hits_o     = out_q.hits[RegModemCtrl];
  assign boot_flag_hits_o = out_q.hits[RegBootFlag];
  assign boot_type_hits_o = out_q.hits[RegBootType];
  assign boot_unit_hits_o = out_q.hits[RegBootUnit];
  assign all_hits_o       = out_q.hits[NumPorts];

  // skid entry only fills behind a waiting head, unknown state held in reset
  `IOPAC_ASSERT_ALWAYS(a_skid_behind_head, !rst_ni || !skid_valid_q || out_valid_q)
  // at most one port counts a match
  `IOPAC_ASSERT(a_single_port_hit, $onehot0(hit.port_hit))
  // final byte leaves a clean scan state
  `IOPAC_ASSERT(a_clear_after_final,
    fire && final_q |=> (total_q == '0) && (seen_q == '0) && (prior_q == '0))
  // total only moves on a hit or a clear
  `IOPAC_ASSERT(a_total_needs_hit, fire && !hit.any_hit |=> total_q == '0 || $stable(total_q))
  // a short image reports no hits
  `IOPAC_ASSERT(a_short_image_zero, out_valid_o && !scan_ok_o |-> all_hits_o == '0)

endmodule
